[rtl/rmdf_pkg.sv]
// shared constants and types for the recent message dedup filter
// no dependencies; imported by every module of the block except rmdf_ram
package rmdf_pkg;

    localparam int RING_DEPTH = 32;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    typedef logic [31:0] hash_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rmdf_q_status_t;

endpackage

[rtl/recent_message_dedup_filter_top.sv]
// Recent message duplicate filter. Key bytes enter one word per cycle and are
// folded into a 32-bit FNV-1a hash; a word with tlast set closes the key. The
// finished hash goes into a two-entry queue, and the ring lookup compares it
// against the filled entries of a 32-entry ring memory, one entry at a time
// through a read state and a compare state (one read port with registered
// data); the byte side keeps taking one word per cycle while the queue has
// room. A miss is written at the ring's next position.
// No clearing pass is needed after reset. depends on rmdf_pkg and all rmdf_ modules
module recent_message_dedup_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // key_hash
    output logic        m_axis_tuser    // is_duplicate
);
    import rmdf_pkg::*;

    rmdf_q_status_t q_status;
    logic           q_push;
    hash_t          q_push_data;
    logic           q_pop;
    hash_t          q_pop_data;

    rmdf_hash u_hash (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    rmdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    rmdf_ring u_ring (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_pop_data    (q_pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/rmdf_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module rmdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rmdf_hash.sv]
// front end: folds key bytes into a running fnv-1a hash, pushes the finished hash
// depends on rmdf_pkg
module rmdf_hash (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // key_byte
    input  logic                   s_axis_tlast,   // final_byte
    input  rmdf_pkg::rmdf_q_status_t q_status,
    output logic                   q_push,
    output rmdf_pkg::hash_t        q_push_data
);
    import rmdf_pkg::*;

    hash_t hash_reg;
    hash_t hash_next;
    hash_t mix;
    hash_t prod;
    logic  accept;

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        mix  = hash_reg ^ {24'd0, s_axis_tdata};
        prod = mix * HASH_PRIME;
        hash_next = hash_reg;
        if (accept) begin
            hash_next = s_axis_tlast ? HASH_BASIS : prod;
        end
    end

    assign q_push      = accept && s_axis_tlast;
    assign q_push_data = prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

[rtl/rmdf_queue.sv]
// two-entry hash queue between the hashing front end and the ring lookup
// depends on rmdf_pkg
module rmdf_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  rmdf_pkg::hash_t         push_data,
    input  logic                    pop,
    output rmdf_pkg::hash_t         pop_data,
    output rmdf_pkg::rmdf_q_status_t status
);
    import rmdf_pkg::*;

    hash_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/rmdf_ring.sv]
// back end: scans the ring of recent hashes, records new ones, drives the result word
// depends on rmdf_pkg and rmdf_ram
module rmdf_ring (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rmdf_pkg::rmdf_q_status_t q_status,
    input  rmdf_pkg::hash_t         q_pop_data,
    output logic                    q_pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [31:0]             m_axis_tdata,  // key_hash
    output logic                    m_axis_tuser   // is_duplicate
);
    import rmdf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t           state_reg;
    hash_t            key_reg;
    logic             dup_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] wpos_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             m_valid_reg;
    hash_t            m_data_reg;
    logic             m_user_reg;

    hash_t            rd_data;
    logic             out_free;
    logic             wr_en;
    logic             last_idx;

    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign wr_en    = (state_reg == ST_DONE) && out_free && !dup_reg;
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);

    rmdf_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wpos_reg),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wpos_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the done state drives the valid flag itself
            if (m_valid_reg && m_axis_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        key_reg   <= q_pop_data;
                        idx_reg   <= '0;
                        dup_reg   <= 1'b0;
                        state_reg <= (fill_reg == '0) ? ST_DONE : ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (rd_data == key_reg) begin
                        dup_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end else if (last_idx) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= key_reg;
                        m_user_reg  <= dup_reg;
                        if (!dup_reg) begin
                            wpos_reg <= (wpos_reg == IDX_W'(RING_DEPTH - 1)) ?
                                        '0 : wpos_reg + 1'b1;
                            if (fill_reg != CNT_W'(RING_DEPTH)) begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_wpos_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != CNT_W'(RING_DEPTH)) |-> (CNT_W'(wpos_reg) == fill_reg))
        else $error("write position out of step with fill count");

    a_scan_in_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (CNT_W'(idx_reg) < fill_reg))
        else $error("scan reached an unfilled entry");

    a_record_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && (fill_reg != CNT_W'(RING_DEPTH))) |=>
        (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("recorded hash did not grow fill count");
`endif

endmodule
